// ===== rtl/core/hnm_pkg.sv =====
`timescale 1ns / 1ps
package hnm_pkg;

   localparam int MAX_TRAIN = 1024;
   localparam int IDX_W     = $clog2(MAX_TRAIN);
   localparam int CNT_W     = IDX_W + 1;
   localparam int WORD_W    = 64;
   localparam int NUM_WORDS = 4;
   localparam int ROW_W     = WORD_W * NUM_WORDS;
   localparam int DIST_W    = 9;
   localparam int POP_W     = 7;
   localparam int Q8_SHIFT  = 8;

   // action codes
   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;
   // spare code, ignored by the block
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // register select (byte address bit 2)
   localparam logic REG_RATIO   = 1'b0;
   localparam logic REG_MAXDIST = 1'b1;

   localparam logic [DIST_W-1:0] DIST_NONE = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // word moving down the cell chain
   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  idx;
      logic [DIST_W-1:0] hdist;
   } tag_type;

   function automatic logic [POP_W-1:0] pop_word(input logic [WORD_W-1:0] x);
      logic [POP_W-1:0] n;
      n = '0;
      for (int b = 0; b < WORD_W; b++) begin
         n = n + POP_W'(x[b]);
      end
      return n;
   endfunction

endpackage

// ===== rtl/core/hnm_cell.sv =====
`timescale 1ns / 1ps
module hnm_cell
   import hnm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [WORD_W-1:0] qword,
   input  tag_type           tag_in,
   input  logic [ROW_W-1:0]  row_in,
   output tag_type           tag_ff,
   output logic [ROW_W-1:0]  row_ff
);

   tag_type tag_in_sum;

   // add this word's distance to the running sum
   always_comb begin
      tag_in_sum       = tag_in;
      tag_in_sum.hdist = tag_in.hdist
                         + DIST_W'(pop_word(qword ^ row_in[WORD_W-1:0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in_sum;
      end
   end

   // hand the remaining words to the next cell
   always_ff @(posedge clock) begin
      row_ff <= {{WORD_W{1'b0}}, row_in[ROW_W-1:WORD_W]};
   end

endmodule

// ===== rtl/core/hamming_two_nn_ratio_matcher.sv =====
`timescale 1ns / 1ps
// Clear and append words are applied as soon as they are accepted.
// A query reads one stored descriptor per cycle from the train memory; each
// descriptor then passes four popcount cells.
// One query is in work at a time; appends and clears may enter while a result waits.
// Reset empties the train set and loads ratio_q8 = 192, max_distance = 257;
// the train memory itself is not cleared.
module hamming_two_nn_ratio_matcher
   import hnm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [WORD_W-1:0]   req_desc_word0,
   input  logic [WORD_W-1:0]   req_desc_word1,
   input  logic [WORD_W-1:0]   req_desc_word2,
   input  logic [WORD_W-1:0]   req_desc_word3,
   input  logic [15:0]         req_query_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_accepted,
   output logic [15:0]         rsp_query_index_res,
   output logic [IDX_W-1:0]    rsp_train_index,
   output logic [DIST_W-1:0]   rsp_distance,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   state_type state_ff, state_in;

   logic [8:0]        ratio_ff;
   logic [DIST_W-1:0] maxd_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  scan_ff;
   logic [ROW_W-1:0]  query_ff;
   logic [15:0]       qidx_ff;

   logic [ROW_W-1:0]  mem [MAX_TRAIN];
   logic [ROW_W-1:0]  mem_q;
   logic              rd_valid_ff;
   logic [IDX_W-1:0]  rd_idx_ff;

   tag_type           tag [NUM_WORDS+1];
   logic [ROW_W-1:0]  row [NUM_WORDS+1];

   logic [DIST_W-1:0] best_ff, second_ff;
   logic [IDX_W-1:0]  best_idx_ff;

   logic              rsp_valid_ff;
   logic              acc_ff;
   logic [15:0]       res_qidx_ff;
   logic [IDX_W-1:0]  res_idx_ff;
   logic [DIST_W-1:0] res_dist_ff;

   logic req_fire, start, issue, load_rsp, pipe_busy, cfg_write;
   logic acc_in;
   logic [17:0] lhs, rhs;

   assign req_fire  = req_valid && !req_stall;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // configuration port
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[2])
         REG_RATIO:   csr_prdata = 32'(ratio_ff);
         REG_MAXDIST: csr_prdata = 32'(maxd_ff);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= 9'd192;
         maxd_ff  <= 9'd257;
      end else if (cfg_write) begin
         if (csr_paddr[2] == REG_RATIO) begin
            ratio_ff <= csr_pwdata[8:0];
         end else begin
            maxd_ff <= csr_pwdata[8:0];
         end
      end
   end

   // pipeline occupancy
   always_comb begin
      pipe_busy = rd_valid_ff;
      for (int c = 1; c <= NUM_WORDS; c++) begin
         pipe_busy = pipe_busy | tag[c].valid;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire && req_action == ACT_QUERY) state_in = ST_SCAN;
         ST_SCAN:  if (scan_ff >= count_ff) state_in = ST_DRAIN;
         ST_DRAIN: if (!pipe_busy) state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      start     = 1'b0;
      issue     = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            start     = req_fire && req_action == ACT_QUERY;
         end
         ST_SCAN:  issue    = scan_ff < count_ff;
         ST_DRAIN: ;
         ST_DONE:  load_rsp = !rsp_valid_ff || !rsp_stall;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // train count and scan pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         scan_ff  <= '0;
      end else begin
         if (req_fire && req_action == ACT_CLEAR) begin
            count_ff <= '0;
         end else if (req_fire && req_action == ACT_APPEND
                      && count_ff < CNT_W'(MAX_TRAIN)) begin
            count_ff <= count_ff + 1'b1;
         end
         if (start) begin
            scan_ff <= '0;
         end else if (issue) begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
   end

   // hold query word
   always_ff @(posedge clock) begin
      if (start) begin
         query_ff <= {req_desc_word3, req_desc_word2, req_desc_word1, req_desc_word0};
         qidx_ff  <= req_query_index;
      end
   end

   // train memory
   always_ff @(posedge clock) begin
      if (req_fire && req_action == ACT_APPEND && count_ff < CNT_W'(MAX_TRAIN)) begin
         mem[count_ff[IDX_W-1:0]] <=
            {req_desc_word3, req_desc_word2, req_desc_word1, req_desc_word0};
      end
      mem_q     <= mem[scan_ff[IDX_W-1:0]];
      rd_idx_ff <= scan_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
      end
   end

   // popcount cell chain
   assign tag[0] = '{valid: rd_valid_ff, idx: rd_idx_ff, hdist: '0};
   assign row[0] = mem_q;

   for (genvar c = 0; c < NUM_WORDS; c++) begin : g_cell
      hnm_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .qword  (query_ff[c*WORD_W +: WORD_W]),
         .tag_in (tag[c]),
         .row_in (row[c]),
         .tag_ff (tag[c+1]),
         .row_ff (row[c+1])
      );
   end

   // keep best and second best; strictly smaller wins
   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff     <= DIST_NONE;
         second_ff   <= DIST_NONE;
         best_idx_ff <= '0;
      end else if (start) begin
         best_ff     <= DIST_NONE;
         second_ff   <= DIST_NONE;
         best_idx_ff <= '0;
      end else if (tag[NUM_WORDS].valid) begin
         if (tag[NUM_WORDS].hdist < best_ff) begin
            second_ff   <= best_ff;
            best_ff     <= tag[NUM_WORDS].hdist;
            best_idx_ff <= tag[NUM_WORDS].idx;
         end else if (tag[NUM_WORDS].hdist < second_ff) begin
            second_ff <= tag[NUM_WORDS].hdist;
         end
      end
   end

   // ratio and distance tests
   assign lhs = 18'({best_ff, {Q8_SHIFT{1'b0}}});
   assign rhs = 18'(ratio_ff) * 18'(second_ff);
   assign acc_in = (count_ff >= CNT_W'(2)) && (lhs < rhs) && (best_ff < maxd_ff);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         acc_ff      <= acc_in;
         res_qidx_ff <= qidx_ff;
         res_idx_ff  <= best_idx_ff;
         res_dist_ff <= (count_ff == '0) ? '0 : best_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = acc_ff;
   assign rsp_query_index_res = res_qidx_ff;
   assign rsp_train_index     = res_idx_ff;
   assign rsp_distance        = res_dist_ff;

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TRAIN))
      else $error("train count beyond capacity");

   a_best_order: assert property (@(posedge clock) disable iff (reset)
      best_ff <= second_ff)
      else $error("best distance above second");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> !pipe_busy)
      else $error("result taken with scan in flight");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word without finished query");

endmodule

// ===== tb/hamming_two_nn_ratio_matcher_tb.sv =====
`timescale 1ns / 1ps
module hamming_two_nn_ratio_matcher_tb;
   import hnm_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 20;

   typedef struct packed {
      logic        accepted;
      logic [15:0] query_index;
      logic [9:0]  train_index;
      logic [8:0]  distance;
   } match_result_type;

   // Mirror of the train set and registers; predicts one result per query word
   class match_scoreboard;
      logic [ROW_W-1:0] store [MAX_TRAIN];
      int               count;
      int               ratio_q8;
      int               maxd_limit;
      match_result_type expected_q [$];
      int               errors;
      int               queries;
      int               accepts;
      int               appends;

      function new();
         count = 0;
         ratio_q8 = 192;
         maxd_limit = 257;
         errors = 0;
         queries = 0;
         accepts = 0;
         appends = 0;
      endfunction

      function void set_reg(logic sel, int value);
         if (sel == REG_RATIO) ratio_q8 = value & 9'h1FF;
         else maxd_limit = value & 9'h1FF;
      endfunction

      function void note_word(logic [1:0] act, logic [ROW_W-1:0] desc, logic [15:0] qi);
         match_result_type r;
         longint best;
         longint second;
         longint d;
         int best_idx;
         best = 64'hFFFF_FFFF;
         second = 64'hFFFF_FFFF;
         best_idx = 0;
         if (act == ACT_CLEAR) begin
            count = 0;
         end else if (act == ACT_APPEND) begin
            appends++;
            if (count < MAX_TRAIN) begin
               store[count] = desc;
               count++;
            end
         end else if (act == ACT_QUERY) begin
            // scan in index order, strictly smaller wins
            for (int i = 0; i < count; i++) begin
               d = $countones(desc ^ store[i]);
               if (d < best) begin
                  second = best;
                  best = d;
                  best_idx = i;
               end else if (d < second) begin
                  second = d;
               end
            end
            r.accepted = 1'b0;
            if (count == 0) begin
               best = 0;
               best_idx = 0;
            end else if (count >= 2) begin
               r.accepted = (best * 256 < ratio_q8 * second) && (best < maxd_limit);
            end
            r.query_index = qi;
            r.train_index = best_idx[9:0];
            r.distance = best[8:0];
            queries++;
            if (r.accepted) accepts++;
            expected_q.insert(expected_q.size(), r);
         end
      endfunction

      function void check_result(match_result_type got);
         match_result_type exp_r;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected result word qi=%0d", got.query_index);
            return;
         end
         exp_r = expected_q.pop_front();
         if (got !== exp_r) begin
            errors++;
            if (errors <= 10)
               $display({"ERROR: result mismatch exp acc=%0d qi=%0d idx=%0d dist=%0d,",
                         " got acc=%0d qi=%0d idx=%0d dist=%0d"},
                        exp_r.accepted, exp_r.query_index, exp_r.train_index,
                        exp_r.distance, got.accepted, got.query_index,
                        got.train_index, got.distance);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_action = ACT_CLEAR;
   logic [WORD_W-1:0]  req_desc_word0 = '0;
   logic [WORD_W-1:0]  req_desc_word1 = '0;
   logic [WORD_W-1:0]  req_desc_word2 = '0;
   logic [WORD_W-1:0]  req_desc_word3 = '0;
   logic [15:0]        req_query_index = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_accepted;
   logic [15:0]        rsp_query_index_res;
   logic [IDX_W-1:0]   rsp_train_index;
   logic [DIST_W-1:0]  rsp_distance;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   match_scoreboard sb = new();
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_request = 0;
   int  hold_left = 0;
   int  quiet_cycles = 0;
   bit  accepted_now;
   bit  running = 1'b1;

   hamming_two_nn_ratio_matcher DUT (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: random stall plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Check each accepted result word
   always @(posedge clock) begin
      match_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.accepted = rsp_accepted;
         got.query_index = rsp_query_index_res;
         got.train_index = rsp_train_index;
         got.distance = rsp_distance;
         sb.check_result(got);
      end
   end

   // Watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((!reset && rsp_valid && !rsp_stall) || accepted_now) quiet_cycles = 0;
      else if (running) quiet_cycles++;
      accepted_now = 1'b0;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired, %0d results still pending", sb.pending());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic csr_write(logic sel, int value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {sel, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_reg(sel, value);
   endtask

   // Offer one word and hold it until accepted
   task automatic send_word(logic [1:0] act, logic [ROW_W-1:0] desc, logic [15:0] qi);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_action <= act;
      {req_desc_word3, req_desc_word2, req_desc_word1, req_desc_word0} <= desc;
      req_query_index <= qi;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      accepted_now = 1'b1;
      sb.note_word(act, desc, qi);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [ROW_W-1:0] rand_desc();
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   // Mostly near-duplicate queries on a small train set, some noise
   task automatic rand_word();
      int r;
      int k;
      logic [ROW_W-1:0] d;
      r = $urandom_range(0, 99);
      if (r < 4 || (sb.count > 16 && r < 15)) begin
         send_word(ACT_CLEAR, rand_desc(), 16'($urandom));
      end else if (r < 8) begin
         send_word(ACT_UNUSED, rand_desc(), 16'($urandom));
      end else if (r < 50) begin
         send_word(ACT_APPEND, rand_desc(), 16'($urandom));
      end else begin
         if (sb.count == 0 || $urandom_range(0, 4) == 0) begin
            d = rand_desc();
         end else begin
            d = sb.store[$urandom_range(0, sb.count - 1)];
            k = $urandom_range(0, 90);
            for (int j = 0; j < k; j++) d[$urandom_range(0, ROW_W - 1)] ^= 1'b1;
         end
         send_word(ACT_QUERY, d, 16'($urandom));
      end
   endtask

   initial begin
      int ratios [5];
      int maxds [5];
      logic [ROW_W-1:0] ones;
      ratios = '{192, 0, 256, 511, 128};
      maxds = '{257, 0, 511, 257, 40};
      ones = '1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty set, single entry, ties, extremes, unused code
      send_word(ACT_QUERY, '0, 16'h0000);
      send_word(ACT_APPEND, '0, 16'h0000);
      send_word(ACT_QUERY, ones, 16'hFFFF);
      send_word(ACT_APPEND, ones, 16'h1234);
      send_word(ACT_QUERY, '0, 16'h0001);
      send_word(ACT_QUERY, ones, 16'h0002);
      send_word(ACT_APPEND, '0, 16'h0003);
      send_word(ACT_QUERY, '0, 16'h0004);
      send_word(ACT_QUERY, 256'h1, 16'h0005);
      send_word(ACT_APPEND, {4{64'hA5A5_5A5A_F00F_0FF0}}, 16'h0006);
      send_word(ACT_QUERY, {4{64'hA5A5_5A5A_F00F_0FF0}} ^ 256'h3, 16'h0007);
      send_word(ACT_UNUSED, ones, 16'hFFFF);
      send_word(ACT_QUERY, {ones[255:128], 128'h0}, 16'h8000);
      send_word(ACT_CLEAR, ones, 16'h0);
      send_word(ACT_QUERY, ones, 16'h0009);
      send_word(ACT_APPEND, {4{64'h0123_4567_89AB_CDEF}}, 16'h0);
      send_word(ACT_QUERY, {4{64'h0123_4567_89AB_CDEF}}, 16'h000A);
      wait_idle();

      for (int p = 0; p < 5; p++) begin
         if (p < 2) begin
            send_idle_pct = 8;
            recv_stall_pct = 53;
         end else if (p < 4) begin
            send_idle_pct = 53;
            recv_stall_pct = 8;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         csr_write(REG_RATIO, ratios[p]);
         csr_write(REG_MAXDIST, maxds[p]);
         for (int n = 0; n < 76; n++) begin
            // long receiver hold-off while words keep coming
            if (p == 1 && n == 20) hold_request = 300;
            // sender pause until all results are back
            if ($urandom_range(0, 39) == 0) wait_idle();
            rand_word();
         end
         wait_idle();
      end
      running = 1'b0;

      $display("Covered %0d queries (%0d accepted), %0d appends, five register settings,",
               sb.queries, sb.accepts, sb.appends);
      $display("empty/single/small train sets and receiver and sender back-pressure.");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/hnm_pkg.sv
rtl/core/hnm_cell.sv
rtl/core/hamming_two_nn_ratio_matcher.sv
tb/hamming_two_nn_ratio_matcher_tb.sv
